// ===== src/rational_arithmetic_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

// ===== src/rau_pkg.sv =====
// types, codes and constants of the rational arithmetic unit
package rau_pkg;

    localparam int DEF_WIDTH = 32;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MIN = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDIV = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_FORM,
        S_GCD,
        S_GSH,
        S_DIVN,
        S_DIVD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic        a_neg;
        logic [31:0] b_num;
        logic [31:0] b_den;
        logic        b_neg;
    } req_t;

    typedef struct packed {
        logic [31:0] res_num;
        logic [31:0] res_den;
        logic        res_neg;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [64:0] diff;
        logic        ge;
    } alu_res_t;

endpackage

// ===== src/rau_alu.sv =====
// shared 65-bit subtract and compare unit
module rau_alu (
    input  logic [64:0]          x,
    input  logic [64:0]          y,
    output rau_pkg::alu_res_t    res
);

    logic [65:0] wide;

    // borrow bit clear means x >= y
    assign wide     = {1'b0, x} - {1'b0, y};
    assign res.diff = wide[64:0];
    assign res.ge   = ~wide[65];

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// top level of the rational arithmetic unit
// Takes one request at a time: opcode plus two sign-magnitude fractions a and b, and
// returns one reduced fraction with a status code (ok, zero denominator, overflow).
// The request port stalls from the cycle after a transfer until the result has been
// moved into the output register; the output register lets a new request enter while
// the previous result still waits downstream. From a request transfer to its result
// in the output register the unit runs the multiply states S_MUL1 and S_MUL2 (and
// S_MUL3 for add and subtract), a combine step, the binary gcd loop (one shift,
// subtract or swap per step until u is zero, on the 65- and 64-bit operands), one
// step per restored common factor of two, two 65-step restoring divisions (numerator
// and denominator by the gcd) on the same single 65-bit subtractor, and the load of
// the output register. Zero denominators skip the reduction. A full output register
// holds the finished result in the done state until it frees up. Cross products come
// from one 32x32 multiplier used in turn by the multiply states. A zero result is
// returned as positive 0/1; any error returns 0/1 positive with a nonzero status.
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rau_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rau_pkg::rsp_t rsp
);

    rau_pkg::state_t state_reg, state_next;

    // latched operands
    logic [2:0]  op_reg, op_next;
    logic [31:0] an_reg, an_next, ad_reg, ad_next;
    logic [31:0] bn_reg, bn_next, bd_reg, bd_next;
    logic        ang_reg, ang_next, bng_reg, bng_next;

    // cross products
    logic [63:0] t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;

    // fraction under reduction
    logic [64:0] n_reg, n_next;
    logic [63:0] d_reg, d_next;
    logic        sign_reg, sign_next;

    // gcd and divider working registers
    logic [64:0] u_reg, u_next, v_reg, v_next, rem_reg, rem_next;
    logic [6:0]  k_reg, k_next, cnt_reg, cnt_next;

    rau_pkg::rsp_t hold_reg, hold_next;
    rau_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // shared multiplier
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;

    // shared subtractor
    logic [64:0]       alu_x, alu_y;
    rau_pkg::alu_res_t alu;
    logic [64:0]       rem_sh, u_step;

    // combine step
    logic [64:0] sum12, f_num;
    logic [63:0] dif12, dif21, f_den;
    logic        ge12, bs, pick_b, f_sign, f_err;

    logic        slot_free, res_zero, res_ovf;

    rau_alu u_alu (
        .x   (alu_x),
        .y   (alu_y),
        .res (alu)
    );

    assign req_stall = (state_reg != rau_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // multiplier operands: mul uses an*bn, ad*bd; the rest an*bd, ad*bn, ad*bd
    always_comb
    begin
        mul_x = ad_reg;
        mul_y = bd_reg;
        case (state_reg)
            rau_pkg::S_MUL1:
            begin
                mul_x = an_reg;
                mul_y = (op_reg == rau_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            rau_pkg::S_MUL2:
            begin
                mul_x = ad_reg;
                mul_y = (op_reg == rau_pkg::OP_MUL) ? bd_reg : bn_reg;
            end
            default:
            begin
                mul_x = ad_reg;
                mul_y = bd_reg;
            end
        endcase
    end

    assign prod = mul_x * mul_y;

    // divider shifts the next dividend bit into the partial remainder
    assign rem_sh = {rem_reg[63:0], u_reg[64]};
    assign alu_x  = ((state_reg == rau_pkg::S_DIVN) || (state_reg == rau_pkg::S_DIVD))
                    ? rem_sh : u_reg;
    assign alu_y  = v_reg;
    assign u_step = {u_reg[63:0], alu.ge};

    // combine cross products into one unreduced fraction
    always_comb
    begin
        sum12  = {1'b0, t1_reg} + {1'b0, t2_reg};
        dif12  = t1_reg - t2_reg;
        dif21  = t2_reg - t1_reg;
        ge12   = (t1_reg >= t2_reg);
        bs     = (op_reg == rau_pkg::OP_SUB) ? !bng_reg : bng_reg;
        pick_b = 1'b0;
        f_num  = '0;
        f_den  = '0;
        f_sign = 1'b0;
        f_err  = (ad_reg == 32'd0) || (bd_reg == 32'd0) ||
                 ((op_reg == rau_pkg::OP_DIV) && (bn_reg == 32'd0));
        case (op_reg)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB:
            begin
                f_den = t3_reg;
                if (ang_reg == bs)
                begin
                    f_num  = sum12;
                    f_sign = ang_reg;
                end
                else if (ge12)
                begin
                    f_num  = {1'b0, dif12};
                    f_sign = ang_reg;
                end
                else
                begin
                    f_num  = {1'b0, dif21};
                    f_sign = bs;
                end
            end
            rau_pkg::OP_MUL, rau_pkg::OP_DIV:
            begin
                f_num  = {1'b0, t1_reg};
                f_den  = t2_reg;
                f_sign = ang_reg ^ bng_reg;
            end
            default:
            begin
                // minimum; unused codes act the same, equal values pick a
                if (ang_reg != bng_reg)
                    pick_b = bng_reg;
                else if (!ang_reg)
                    pick_b = (t2_reg < t1_reg);
                else
                    pick_b = (t2_reg > t1_reg);
                f_num  = {33'd0, (pick_b ? bn_reg : an_reg)};
                f_den  = {32'd0, (pick_b ? bd_reg : ad_reg)};
                f_sign = pick_b ? bng_reg : ang_reg;
            end
        endcase
    end

    // final quotients: n_reg holds num/g, u_step holds den/g at the last divide step
    assign res_zero = (n_reg == 65'd0);
    assign res_ovf  = ((n_reg >> WIDTH) != 65'd0) || ((u_step >> WIDTH) != 65'd0);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        an_next        = an_reg;
        ad_next        = ad_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        ang_next       = ang_reg;
        bng_next       = bng_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        t3_next        = t3_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sign_next      = sign_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        rem_next       = rem_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        hold_next      = hold_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            rau_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    an_next    = req.a_num;
                    ad_next    = req.a_den;
                    bn_next    = req.b_num;
                    bd_next    = req.b_den;
                    // a zero numerator counts as positive
                    ang_next   = req.a_neg && (req.a_num != 32'd0);
                    bng_next   = req.b_neg && (req.b_num != 32'd0);
                    state_next = rau_pkg::S_MUL1;
                end
            end
            rau_pkg::S_MUL1:
            begin
                t1_next    = prod;
                state_next = rau_pkg::S_MUL2;
            end
            rau_pkg::S_MUL2:
            begin
                t2_next = prod;
                if ((op_reg == rau_pkg::OP_ADD) || (op_reg == rau_pkg::OP_SUB))
                    state_next = rau_pkg::S_MUL3;
                else
                    state_next = rau_pkg::S_FORM;
            end
            rau_pkg::S_MUL3:
            begin
                t3_next    = prod;
                state_next = rau_pkg::S_FORM;
            end
            rau_pkg::S_FORM:
            begin
                if (f_err)
                begin
                    hold_next.res_num = 32'd0;
                    hold_next.res_den = 32'd1;
                    hold_next.res_neg = 1'b0;
                    hold_next.status  = rau_pkg::ST_ZDIV;
                    state_next        = rau_pkg::S_DONE;
                end
                else
                begin
                    n_next     = f_num;
                    d_next     = f_den;
                    sign_next  = f_sign;
                    u_next     = f_num;
                    v_next     = {1'b0, f_den};
                    k_next     = 7'd0;
                    state_next = rau_pkg::S_GCD;
                end
            end
            rau_pkg::S_GCD:
            begin
                // binary gcd, v never reaches zero
                if (u_reg == 65'd0)
                    state_next = rau_pkg::S_GSH;
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 7'd1;
                end
                else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (alu.ge)
                    u_next = alu.diff;
                else
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            rau_pkg::S_GSH:
            begin
                // restore the common power of two
                if (k_reg != 7'd0)
                begin
                    v_next = v_reg << 1;
                    k_next = k_reg - 7'd1;
                end
                else
                begin
                    u_next     = n_reg;
                    rem_next   = 65'd0;
                    cnt_next   = 7'd64;
                    state_next = rau_pkg::S_DIVN;
                end
            end
            rau_pkg::S_DIVN:
            begin
                rem_next = alu.ge ? alu.diff : rem_sh;
                u_next   = u_step;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    n_next     = u_step;
                    u_next     = {1'b0, d_reg};
                    rem_next   = 65'd0;
                    cnt_next   = 7'd64;
                    state_next = rau_pkg::S_DIVD;
                end
            end
            rau_pkg::S_DIVD:
            begin
                rem_next = alu.ge ? alu.diff : rem_sh;
                u_next   = u_step;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    if (res_ovf)
                    begin
                        hold_next.res_num = 32'd0;
                        hold_next.res_den = 32'd1;
                        hold_next.res_neg = 1'b0;
                        hold_next.status  = rau_pkg::ST_OVF;
                    end
                    else
                    begin
                        hold_next.res_num = n_reg[31:0];
                        hold_next.res_den = res_zero ? 32'd1 : u_step[31:0];
                        hold_next.res_neg = res_zero ? 1'b0 : sign_reg;
                        hold_next.status  = rau_pkg::ST_OK;
                    end
                    state_next = rau_pkg::S_DONE;
                end
            end
            rau_pkg::S_DONE:
            begin
                // wait for the output register to free up
                if (slot_free)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = rau_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rau_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        ang_reg  <= ang_next;
        bng_reg  <= bng_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        t3_reg   <= t3_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        sign_reg <= sign_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// ===== src/rau_checker.sv =====
// port-level checks of the rational arithmetic unit and their binding
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input rau_pkg::rsp_t rsp
);

    // a held result stays put
    `RAU_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // one item at a time: busy right after a request transfer
    `RAU_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall)

    // error results carry the fixed 0/1 positive value
    `RAU_ASSERT_IMP(a_err_value, rsp_valid && (rsp.status != rau_pkg::ST_OK), (rsp.res_num == 32'd0) && (rsp.res_den == 32'd1) && !rsp.res_neg)

    // zero comes out as positive 0/1
    `RAU_ASSERT_IMP(a_zero_form, rsp_valid && (rsp.status == rau_pkg::ST_OK) && (rsp.res_num == 32'd0), (rsp.res_den == 32'd1) && !rsp.res_neg)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== sim/tb_rational_arithmetic_unit.sv =====
// self-checking testbench for the rational arithmetic unit
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;

    // opcodes above minimum fall back to minimum
    localparam logic [2:0] OP_SPARE = 3'd7;
    localparam logic [31:0] MAG_MAX = 32'hFFFF_FFFF;
    localparam int ITEMS_PER_PHASE = 444;
    localparam int LONG_HOLD = 1500;

    typedef struct {
        rau_pkg::req_t req;
        bit            known;
        rau_pkg::rsp_t rsp;
    } vector_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    rau_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    rau_pkg::rsp_t rsp;

    rau_pkg::rsp_t pending_results[$];
    vector_t       vectors[$];
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_go;
    int            hold_left;
    int            fail_count;
    int            checked;
    int            error_results;
    int            overflow_results;

    rational_arithmetic_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // reduce n/d by their gcd, flag overflow past the datapath width
    function automatic rau_pkg::rsp_t reduce_fraction(logic [64:0] n, logic [64:0] d,
                                                      logic neg);
        logic [64:0] x;
        logic [64:0] y;
        logic [64:0] t;
        logic [64:0] q;
        logic [64:0] dq;
        logic [64:0] limit;
        rau_pkg::rsp_t r;
        limit = 65'd1 << rau_pkg::DEF_WIDTH;
        x = d;
        y = n;
        while (y != 65'd0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        q = n / x;
        dq = d / x;
        if (q >= limit || dq >= limit)
        begin
            r = '{res_num: '0, res_den: 32'd1, res_neg: 1'b0, status: rau_pkg::ST_OVF};
            return r;
        end
        if (q == 65'd0)
        begin
            dq = 65'd1;
            neg = 1'b0;
        end
        r = '{res_num: q[31:0], res_den: dq[31:0], res_neg: neg, status: rau_pkg::ST_OK};
        return r;
    endfunction

    // full-width cross products, signs normalized so that zero is positive
    function automatic rau_pkg::rsp_t rational_result(rau_pkg::req_t r);
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] bn;
        logic [63:0] bd;
        logic [63:0] t1;
        logic [63:0] t2;
        logic        a_sgn;
        logic        b_sgn;
        logic        bs;
        logic        pick_b;
        rau_pkg::rsp_t e;
        an = r.a_num;
        ad = r.a_den;
        bn = r.b_num;
        bd = r.b_den;
        a_sgn = r.a_neg && an != 0;
        b_sgn = r.b_neg && bn != 0;
        t1 = an * bd;
        t2 = ad * bn;
        if (ad == 0 || bd == 0 || (r.opcode == rau_pkg::OP_DIV && bn == 0))
        begin
            e = '{res_num: '0, res_den: 32'd1, res_neg: 1'b0, status: rau_pkg::ST_ZDIV};
            return e;
        end
        case (r.opcode)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB:
            begin
                bs = (r.opcode == rau_pkg::OP_SUB) ? !b_sgn : b_sgn;
                if (a_sgn == bs)
                    return reduce_fraction({1'b0, t1} + {1'b0, t2}, ad * bd, a_sgn);
                if (t1 >= t2)
                    return reduce_fraction(t1 - t2, ad * bd, a_sgn);
                return reduce_fraction(t2 - t1, ad * bd, bs);
            end
            rau_pkg::OP_MUL: return reduce_fraction(an * bn, ad * bd, a_sgn != b_sgn);
            rau_pkg::OP_DIV: return reduce_fraction(t1, ad * bn, a_sgn != b_sgn);
            default:
            begin
                // minimum: a wins ties
                if (a_sgn != b_sgn)
                    pick_b = b_sgn;
                else if (!a_sgn)
                    pick_b = t2 < t1;
                else
                    pick_b = t2 > t1;
                if (pick_b)
                    return reduce_fraction(bn, bd, b_sgn);
                return reduce_fraction(an, ad, a_sgn);
            end
        endcase
    endfunction

    function automatic rau_pkg::req_t make_req(logic [2:0] op, logic [31:0] an,
                                               logic [31:0] ad, logic ang,
                                               logic [31:0] bn, logic [31:0] bd,
                                               logic bng);
        rau_pkg::req_t r;
        r = '{opcode: op, a_num: an, a_den: ad, a_neg: ang,
              b_num: bn, b_den: bd, b_neg: bng};
        return r;
    endfunction

    function automatic void add_vector(rau_pkg::req_t r, bit known, rau_pkg::rsp_t e);
        vector_t v;
        v.req = r;
        v.known = known;
        v.rsp = e;
        vectors.push_back(v);
    endfunction

    // magnitudes weighted toward small values so most results stay in range
    function automatic logic [31:0] random_magnitude(bit is_den);
        int pick;
        pick = $urandom_range(29);
        if (pick == 0)
            return is_den ? 32'd0 : MAG_MAX;
        if (pick < 3)
            return is_den ? MAG_MAX : 32'd0;
        if (pick < 15)
            return $urandom_range(1, 40);
        if (pick < 22)
            return $urandom_range(1, 65535);
        return $urandom;
    endfunction

    function automatic rau_pkg::req_t random_req();
        return make_req(3'($urandom_range(7)),
                        random_magnitude(1'b0), random_magnitude(1'b1),
                        1'($urandom_range(1)),
                        random_magnitude(1'b0), random_magnitude(1'b1),
                        1'($urandom_range(1)));
    endfunction

    // one transfer on the request side, with random idle cycles ahead of it
    task automatic send_request(rau_pkg::req_t r, bit known, rau_pkg::rsp_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(known ? e : rational_result(r));
        @(negedge clk);
    endtask

    // receiver: random stall, or one long hold-off when asked
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = LONG_HOLD;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker: every transfer against the oldest expectation
    always @(posedge clk)
    begin
        rau_pkg::rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer %p", rsp);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                checked++;
                if (e.status == rau_pkg::ST_ZDIV)
                    error_results++;
                if (e.status == rau_pkg::ST_OVF)
                    overflow_results++;
                if (rsp.res_num !== e.res_num)
                begin
                    $error("res_num expected %0d got %0d", e.res_num, rsp.res_num);
                    fail_count++;
                end
                if (rsp.res_den !== e.res_den)
                begin
                    $error("res_den expected %0d got %0d", e.res_den, rsp.res_den);
                    fail_count++;
                end
                if (rsp.res_neg !== e.res_neg)
                begin
                    $error("res_neg expected %0d got %0d", e.res_neg, rsp.res_neg);
                    fail_count++;
                end
                if (rsp.status !== e.status)
                begin
                    $error("status expected %0d got %0d", e.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: reports a mismatch if the run does not finish in time
    initial
    begin
        #60_000_000;
        $display("rational_arithmetic_unit: mismatch");
        $finish;
    end

    initial
    begin
        rau_pkg::rsp_t err_zdiv;
        rau_pkg::rsp_t err_ovf;
        rau_pkg::rsp_t zero_res;
        int            ph;
        err_zdiv = '{res_num: '0, res_den: 32'd1, res_neg: 1'b0, status: rau_pkg::ST_ZDIV};
        err_ovf = '{res_num: '0, res_den: 32'd1, res_neg: 1'b0, status: rau_pkg::ST_OVF};
        zero_res = '{res_num: '0, res_den: 32'd1, res_neg: 1'b0, status: rau_pkg::ST_OK};
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b0;
        hold_left = 0;
        fail_count = 0;
        checked = 0;
        error_results = 0;
        overflow_results = 0;

        // directed table; expected results typed in where obvious
        // zero denominators and division by zero
        add_vector(make_req(rau_pkg::OP_ADD, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1, 1'b0), 1,
                   err_zdiv);
        add_vector(make_req(rau_pkg::OP_MUL, 32'd1, 32'd1, 1'b0, 32'd1, 32'd0, 1'b1), 1,
                   err_zdiv);
        add_vector(make_req(rau_pkg::OP_DIV, 32'd3, 32'd4, 1'b1, 32'd0, 32'd5, 1'b1), 1,
                   err_zdiv);
        // overflow of the sum, of the product and of the quotient
        add_vector(make_req(rau_pkg::OP_ADD, MAG_MAX, 32'd1, 1'b0, MAG_MAX, 32'd1, 1'b0), 1,
                   err_ovf);
        add_vector(make_req(rau_pkg::OP_MUL, MAG_MAX, 32'd1, 1'b1, MAG_MAX, 32'd1, 1'b0), 1,
                   err_ovf);
        add_vector(make_req(rau_pkg::OP_DIV, 32'd1, MAG_MAX, 1'b0, MAG_MAX, 32'd1, 1'b0), 1,
                   err_ovf);
        // zero results come back as positive 0/1, negative zero is positive
        add_vector(make_req(rau_pkg::OP_SUB, 32'd5, 32'd7, 1'b1, 32'd5, 32'd7, 1'b1), 1,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_MUL, 32'd0, 32'd9, 1'b1, 32'd4, 32'd3, 1'b1), 1,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_MIN, 32'd0, 32'd3, 1'b1, 32'd0, 32'd8, 1'b0), 1,
                   zero_res);
        // ordinary arithmetic, left to the predictor
        add_vector(make_req(rau_pkg::OP_ADD, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3, 1'b1), 0,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_SUB, 32'd3, 32'd4, 1'b1, 32'd1, 32'd4, 1'b1), 0,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_MUL, 32'd6, 32'd35, 1'b1, 32'd14, 32'd9, 1'b0), 0,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_DIV, 32'd2, 32'd3, 1'b1, 32'd4, 32'd9, 1'b1), 0,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_ADD, MAG_MAX, MAG_MAX, 1'b1, MAG_MAX, MAG_MAX, 1'b1),
                   0, zero_res);
        add_vector(make_req(rau_pkg::OP_SUB, MAG_MAX, 32'd2, 1'b0, MAG_MAX, 32'd3, 1'b0), 0,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_DIV, MAG_MAX, MAG_MAX - 32'd1, 1'b0, MAG_MAX,
                            MAG_MAX, 1'b1), 0, zero_res);
        // minimum: mixed signs, both negative, equal values, both positive, unused opcodes
        add_vector(make_req(rau_pkg::OP_MIN, 32'd1, 32'd2, 1'b0, 32'd5, 32'd1, 1'b1), 0,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_MIN, 32'd1, 32'd2, 1'b1, 32'd2, 32'd3, 1'b1), 0,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_MIN, 32'd2, 32'd4, 1'b0, 32'd3, 32'd6, 1'b0), 0,
                   zero_res);
        add_vector(make_req(rau_pkg::OP_MIN, 32'd7, 32'd3, 1'b0, 32'd5, 32'd3, 1'b0), 0,
                   zero_res);
        add_vector(make_req(OP_SPARE, 32'd9, 32'd4, 1'b1, 32'd1, 32'd4, 1'b0), 0, zero_res);
        add_vector(make_req(rau_pkg::OP_MIN + 3'd1, MAG_MAX, 32'd6, 1'b0, 32'd8, 32'd12,
                            1'b0), 0, zero_res);

        // reset held low, released away from the active edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (vectors[i])
            send_request(vectors[i].req, vectors[i].known, vectors[i].rsp);
        req_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);

        // three phases: receiver sparse, sender sparse, then back to back
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 71 : 0;
            recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 17 : 0;
            // long receiver hold-off so the unit backs up into its input
            if (ph == 2)
                hold_go = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_request(random_req(), 0, zero_res);
            req_valid <= 1'b0;
            // sender pauses until the unit has drained
            wait (pending_results.size() == 0);
            @(negedge clk);
        end

        repeat (500) @(posedge clk);
        $display("checked %0d result transfers (%0d zero-denominator, %0d overflow)",
                 checked, error_results, overflow_results);
        $display("covered all opcodes, sign cases and three handshake idling profiles");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("rational_arithmetic_unit: match");
        else
            $display("rational_arithmetic_unit: mismatch");
        $finish;
    end

endmodule
